### hdl/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg: shared definitions for the keyed record table
// Sizes, request and status codes, controller states and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

  // Table geometry.
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Field widths.
  localparam int KEY_W = 16;
  localparam int AMT_W = 16;
  localparam int REQ_W = 2;
  localparam int STS_W = 3;

  // Request codes; the fourth code is unused and answers not found.
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2
  } req_t;

  // Result status codes.
  typedef enum logic [STS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_FOUND     = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_SWAP = 2'd2,
    S_DONE = 2'd3
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;        // capture the request, restart the scan
    logic    scan_rd;     // read the entry at the scan index and advance it
    logic    last_rd;     // read the last live entry
    logic    ins_wr;      // append the request record
    logic    swap_wr;     // write the last entry into the hit slot
    logic    cnt_dec;     // drop one live entry
    logic    res_ld;      // capture a result
    logic    res_from_rd; // result amount comes from the read data
    status_t res_status;
    logic    out_ld;      // move the result into the output register
  } krt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             key_hit;   // read data valid and key matches
    logic             rd_vld;    // a read is in flight
    logic             scan_more; // live entries remain to be read
    logic             full;
    logic             hit_last;  // the hit is on the last live entry
    logic             out_free;  // output register can take a result
  } krt_sts_t;

endpackage

`default_nettype wire

### hdl/krt_if.sv
// ----------------------------------------------------------------------------
// krt_if: request and response channels of the keyed record table
// Valid and ready handshake; a transfer happens when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface krt_req_if;
  import krt_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] key;
  logic [AMT_W-1:0] amount_in;

  modport source (output valid, req_type, key, amount_in, input ready);
  modport sink   (input valid, req_type, key, amount_in, output ready);
endinterface

interface krt_rsp_if;
  import krt_pkg::*;

  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [AMT_W-1:0] amount_out;

  modport source (output valid, status, amount_out, input ready);
  modport sink   (input valid, status, amount_out, output ready);
endinterface

`default_nettype wire

### hdl/keyed_record_table.sv
// ----------------------------------------------------------------------------
// keyed_record_table: key and amount table with linear search
// Insert, delete by key with last-entry swap, and search by key.
//
// Usage:
//   in_ch carries one request (req_type, key, amount_in); out_ch returns
//   exactly one result (status, amount_out) per request, in request order.
//   A request is taken only while the controller is idle. The key is then
//   compared against the live entries one per cycle through the single
//   registered read port of the record memory; a miss reads every live
//   entry, at most ENTRIES, and a hit ends the scan early. A delete that
//   moves the last entry into the hole adds the swap state, since the last
//   entry is read in the cycle of the hit and written in the next. One
//   request is in work at a time.
//   The result sits in an output register. A new request is accepted while
//   an earlier result still waits; when the receiver stalls, the finished
//   result of the next request waits in the result register, with the
//   controller holding, until the output register frees. Reset empties the
//   table at once: the live count goes to zero and no memory clearing pass
//   is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_record_table (
  input  wire logic clk,
  input  wire logic rst_n,
  krt_req_if.sink   in_ch,
  krt_rsp_if.source out_ch
);
  import krt_pkg::*;

  krt_cmd_t cmd;
  krt_sts_t sts;

  // Sequencer.
  krt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage, compare and output register.
  krt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req_type (in_ch.req_type),
    .in_key      (in_ch.key),
    .in_amount   (in_ch.amount_in),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.status),
    .out_amount  (out_ch.amount_out)
  );

endmodule

`default_nettype wire

### hdl/krt_dp.sv
// ----------------------------------------------------------------------------
// krt_dp: datapath of the keyed record table
// Record memory, live count, scan counter, key compare and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [krt_pkg::REQ_W-1:0] in_req_type,
  input  wire logic [krt_pkg::KEY_W-1:0] in_key,
  input  wire logic [krt_pkg::AMT_W-1:0] in_amount,
  input  wire krt_pkg::krt_cmd_t    cmd,
  output krt_pkg::krt_sts_t         sts,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [krt_pkg::STS_W-1:0] out_status,
  output logic [krt_pkg::AMT_W-1:0] out_amount
);
  import krt_pkg::*;

  localparam int REC_W = KEY_W + AMT_W;

  logic [REC_W-1:0] mem [ENTRIES];

  logic [REQ_W-1:0] req_r;
  logic [KEY_W-1:0] key_r;
  logic [AMT_W-1:0] amt_r;
  logic [CNT_W-1:0] scan_idx_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] slot_r;
  logic [REC_W-1:0] rd_data_r;
  logic             rd_vld_r;
  logic [STS_W-1:0] res_status_r;
  logic [AMT_W-1:0] res_amt_r;
  logic             out_valid_r;
  logic [STS_W-1:0] out_status_r;
  logic [AMT_W-1:0] out_amt_r;

  logic [IDX_W-1:0] last_idx;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [REC_W-1:0] mem_wd;
  logic             mem_re;
  logic [IDX_W-1:0] mem_ra;
  logic [KEY_W-1:0] rd_key;
  logic [AMT_W-1:0] rd_amt;

  // Address and data selection for the record memory.
  always_comb begin
    last_idx = IDX_W'(count_r - CNT_W'(1));
    mem_we   = cmd.ins_wr | cmd.swap_wr;
    mem_wa   = cmd.ins_wr ? count_r[IDX_W-1:0] : slot_r;
    mem_wd   = cmd.ins_wr ? {key_r, amt_r} : rd_data_r;
    mem_re   = cmd.scan_rd | cmd.last_rd;
    mem_ra   = cmd.last_rd ? last_idx : scan_idx_r[IDX_W-1:0];
    rd_key   = rd_data_r[REC_W-1:AMT_W];
    rd_amt   = rd_data_r[AMT_W-1:0];
  end

  // Record memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Request capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      key_r <= in_key;
      amt_r <= in_amount;
    end
    if (cmd.scan_rd) begin
      rd_idx_r <= scan_idx_r[IDX_W-1:0];
    end
    if (sts.key_hit) begin
      slot_r <= rd_idx_r;
    end
    if (cmd.res_ld) begin
      res_status_r <= cmd.res_status;
      res_amt_r    <= cmd.res_from_rd ? rd_amt : '0;
    end
    if (cmd.out_ld) begin
      out_status_r <= res_status_r;
      out_amt_r    <= res_amt_r;
    end
  end

  // Control registers: scan index, read valid, live count, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_rd) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end
      rd_vld_r <= mem_re;
      if (cmd.ins_wr) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.req       = req_r;
    sts.rd_vld    = rd_vld_r;
    sts.key_hit   = rd_vld_r && (rd_key == key_r);
    sts.scan_more = scan_idx_r < count_r;
    sts.full      = count_r == CNT_W'(ENTRIES);
    sts.hit_last  = rd_idx_r == last_idx;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_amount = out_amt_r;

endmodule

`default_nettype wire

### hdl/krt_ctrl.sv
// ----------------------------------------------------------------------------
// krt_ctrl: controller of the keyed record table
// Sequences the capture, the linear scan, the swap on delete and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire krt_pkg::krt_sts_t sts,
  output krt_pkg::krt_cmd_t      cmd
);
  import krt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = ST_NOTFOUND;
    in_ready       = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (sts.key_hit) begin
          // The compared entry holds the key.
          case (sts.req)
            REQ_INSERT: begin
              cmd.res_ld     = 1'b1;
              cmd.res_status = ST_DUPLICATE;
              state_nxt      = S_DONE;
            end
            REQ_SEARCH: begin
              cmd.res_ld      = 1'b1;
              cmd.res_from_rd = 1'b1;
              cmd.res_status  = ST_FOUND;
              state_nxt       = S_DONE;
            end
            REQ_DELETE: begin
              if (sts.hit_last) begin
                cmd.cnt_dec    = 1'b1;
                cmd.res_ld     = 1'b1;
                cmd.res_status = ST_FOUND;
                state_nxt      = S_DONE;
              end else begin
                cmd.last_rd = 1'b1;
                state_nxt   = S_SWAP;
              end
            end
            default: begin
              cmd.res_ld     = 1'b1;
              cmd.res_status = ST_NOTFOUND;
              state_nxt      = S_DONE;
            end
          endcase
        end else if (sts.scan_more) begin
          cmd.scan_rd = 1'b1;
        end else if (!sts.rd_vld) begin
          // Every live entry has been compared without a match.
          cmd.res_ld = 1'b1;
          state_nxt  = S_DONE;
          if (sts.req == REQ_INSERT) begin
            if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.ins_wr     = 1'b1;
              cmd.res_status = ST_INSERTED;
            end
          end else begin
            cmd.res_status = ST_NOTFOUND;
          end
        end
      end

      S_SWAP: begin
        // The last entry's record has been read; move it into the hole.
        cmd.swap_wr    = 1'b1;
        cmd.cnt_dec    = 1'b1;
        cmd.res_ld     = 1'b1;
        cmd.res_status = ST_FOUND;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the keyed record table
// Sends insert, delete and search requests with random gaps on both channels.
// A software copy of the table predicts each response, and every response
// transfer is compared field by field with the oldest prediction. Phases
// fill the table to capacity, drain it, and mix operations over a small key
// pool, so duplicate, full and swap cases occur often.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import krt_pkg::*;

  localparam int NUM_ITEMS   = 1200;
  localparam int MAX_IDLE    = 14;
  localparam int POOL_SIZE   = 16;
  localparam int SETTLE_WAIT = ENTRIES + 40;
  localparam int CYCLE_LIMIT = 1000000;

  // The fourth request code has no enum member in the package.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    status_t          status;
    logic [AMT_W-1:0] amount;
  } table_result_t;

  // Shadow copy of the table; it predicts the response of each request.
  class record_table_model;
    logic [KEY_W-1:0] keys[ENTRIES];
    logic [AMT_W-1:0] amounts[ENTRIES];
    int               count;
    table_result_t    awaited[$];
    int               mismatches;

    function new();
      count      = 0;
      mismatches = 0;
    endfunction

    // Only live entries take part in the search.
    function int find_slot(logic [KEY_W-1:0] k);
      for (int i = 0; i < count; i++) begin
        if (keys[i] == k) return i;
      end
      return -1;
    endfunction

    // Applies an accepted request to the shadow table and queues its response.
    function void take_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] k,
                               logic [AMT_W-1:0] a);
      table_result_t r;
      int            slot;
      r.status = ST_NOTFOUND;
      r.amount = '0;
      slot     = find_slot(k);
      case (req)
        REQ_INSERT: begin
          if (slot >= 0) begin
            r.status = ST_DUPLICATE;
          end else if (count >= ENTRIES) begin
            r.status = ST_FULL;
          end else begin
            keys[count]    = k;
            amounts[count] = a;
            count++;
            r.status = ST_INSERTED;
          end
        end
        REQ_DELETE: begin
          // The last live entry moves into the hole.
          if (slot >= 0) begin
            keys[slot]    = keys[count-1];
            amounts[slot] = amounts[count-1];
            count--;
            r.status = ST_FOUND;
          end
        end
        REQ_SEARCH: begin
          if (slot >= 0) begin
            r.status = ST_FOUND;
            r.amount = amounts[slot];
          end
        end
        default: begin
        end
      endcase
      awaited.push_back(r);
    endfunction

    // Compares one response transfer with the oldest prediction.
    function void check_result(logic [STS_W-1:0] st, logic [AMT_W-1:0] a);
      table_result_t r;
      if (awaited.size() == 0) begin
        $display("%0t: response with nothing pending: expected none, actual status %0d amount %h",
                 $time, st, a);
        mismatches++;
        return;
      end
      r = awaited.pop_front();
      if (st !== r.status) begin
        $display("%0t: status mismatch: expected %0d (%s), actual %0d",
                 $time, r.status, r.status.name(), st);
        mismatches++;
      end
      if (a !== r.amount) begin
        $display("%0t: amount mismatch: expected %h, actual %h", $time, r.amount, a);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  krt_req_if in_ch ();
  krt_rsp_if out_ch ();

  keyed_record_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  record_table_model table_model;
  logic [KEY_W-1:0]  key_pool[POOL_SIZE];
  int                items_sent;
  int                cycles;
  bit                calm;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Response monitor.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      table_model.check_result(out_ch.status, out_ch.amount_out);
    end
  end

  // Receiver: a random stall before each response transfer.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Sends one request after a random gap and waits for its transfer.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] k,
                              input logic [AMT_W-1:0] a);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= req;
    in_ch.key       <= k;
    in_ch.amount_in <= a;
    do @(posedge clk); while (!in_ch.ready);
    table_model.take_request(req, k, a);
    items_sent++;
  endtask

  // Drops the request and holds off until every predicted response has arrived.
  task automatic wait_for_responses();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (table_model.awaited.size() != 0) @(posedge clk);
  endtask

  // A live key with the given chance, else a pool key or a fully random one.
  function automatic logic [KEY_W-1:0] pick_key(int live_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (table_model.count > 0 && roll < live_pct) begin
      return table_model.keys[$urandom_range(0, table_model.count - 1)];
    end
    if ($urandom_range(0, 1) == 0) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return KEY_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Amounts lean toward the extremes now and then.
  function automatic logic [AMT_W-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return AMT_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Fills the table to capacity, then presses on it with new and live keys.
  task automatic fill_phase();
    while (table_model.count < ENTRIES) begin
      send_request(REQ_INSERT, pick_key(10), pick_amount());
    end
    repeat (6) begin
      send_request(REQ_INSERT, pick_key(50), pick_amount());
    end
    send_request(REQ_SEARCH, pick_key(80), pick_amount());
  endtask

  // Deletes live keys until the table is empty, with searches in between.
  task automatic drain_phase();
    while (table_model.count > 0) begin
      if ($urandom_range(0, 99) < 80) begin
        send_request(REQ_DELETE, pick_key(100), pick_amount());
      end else begin
        send_request(REQ_SEARCH, pick_key(50), pick_amount());
      end
    end
    send_request(REQ_DELETE, pick_key(0), pick_amount());
    send_request(REQ_SEARCH, pick_key(0), pick_amount());
  endtask

  // Random mix of all request codes over mostly live and pool keys.
  task automatic mixed_phase(input int n);
    int               roll;
    logic [REQ_W-1:0] req;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 40)      req = REQ_INSERT;
      else if (roll < 70) req = REQ_DELETE;
      else if (roll < 95) req = REQ_SEARCH;
      else                req = REQ_UNUSED;
      send_request(req, pick_key(60), pick_amount());
    end
  endtask

  // Main sequence.
  initial begin
    table_model = new();
    items_sent  = 0;
    cycles      = 0;
    calm        = 1'b0;
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom_range(0, 16'hFFFF));
    key_pool[0] = '0;
    key_pool[1] = '1;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.req_type  <= REQ_INSERT;
    in_ch.key       <= '0;
    in_ch.amount_in <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes, duplicates, the unused code and swaps.
    send_request(REQ_SEARCH, 16'h0000, 16'h0000);
    send_request(REQ_DELETE, 16'h0000, 16'hFFFF);
    send_request(REQ_INSERT, 16'h0000, 16'h0000);
    send_request(REQ_INSERT, 16'hFFFF, 16'hFFFF);
    send_request(REQ_INSERT, 16'h0000, 16'h1234);
    send_request(REQ_SEARCH, 16'h0000, 16'hFFFF);
    send_request(REQ_SEARCH, 16'hFFFF, 16'h0000);
    send_request(REQ_SEARCH, 16'h0001, 16'h0000);
    send_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
    send_request(REQ_INSERT, 16'h5555, 16'hAAAA);
    send_request(REQ_INSERT, 16'hAAAA, 16'h5555);
    // Deleting the first entry moves the last one into slot zero.
    send_request(REQ_DELETE, 16'h0000, 16'h0000);
    send_request(REQ_SEARCH, 16'hAAAA, 16'h0000);
    send_request(REQ_SEARCH, 16'h0000, 16'h0000);
    // The last live entry is simply dropped.
    send_request(REQ_DELETE, 16'h5555, 16'h0000);
    send_request(REQ_SEARCH, 16'h5555, 16'h0000);
    send_request(REQ_DELETE, 16'h5555, 16'h0000);
    send_request(REQ_INSERT, 16'h1234, 16'h0000);
    send_request(REQ_UNUSED, 16'h0000, 16'h0000);
    send_request(REQ_DELETE, 16'hFFFF, 16'h0000);
    send_request(REQ_SEARCH, 16'h1234, 16'hFFFF);
    send_request(REQ_SEARCH, 16'hFFFF, 16'h0000);
    wait_for_responses();

    // Full table and empty table at least once each.
    fill_phase();
    drain_phase();

    // Random phases; some run without idling, some end with a hold-off.
    while (items_sent < NUM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       fill_phase();
        1:       drain_phase();
        default: mixed_phase(40);
      endcase
      if ($urandom_range(0, 2) == 0) wait_for_responses();
    end
    calm = 1'b0;

    wait_for_responses();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (table_model.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hdl/krt_pkg.sv
hdl/krt_if.sv
hdl/krt_dp.sv
hdl/krt_ctrl.sv
hdl/keyed_record_table.sv
test/tb.sv
